// ----- rtl/core/abgt_pkg.sv -----
// Shared types and constants for the accelerometer beat and gesture trigger.
package abgt_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 11;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] TRIGGER_DIFF_RST   = 10'd40;
  localparam logic [DELAY_W-1:0]  RETRIGGER_DELAY_RST = 16'd100;
  localparam logic [LEVEL_W-1:0]  SHAKE_LEVEL_RST    = 11'd300;
  localparam logic [HOLD_W-1:0]   GESTURE_HOLD_RST   = 8'd20;
  localparam logic [LEVEL_W-1:0]  REST_LEVEL_RST     = 11'd25;
  localparam logic [SAMPLE_W-1:0] REST_LOW_MEAN_RST  = 10'd450;
  localparam logic [SAMPLE_W-1:0] REST_HIGH_MEAN_RST = 10'd550;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_DIFF    = 3'd0,
    REG_RETRIGGER_DELAY = 3'd1,
    REG_SHAKE_LEVEL     = 3'd2,
    REG_GESTURE_HOLD    = 3'd3,
    REG_REST_LEVEL      = 3'd4,
    REG_REST_LOW_MEAN   = 3'd5,
    REG_REST_HIGH_MEAN  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] hit_right;
    logic [SAMPLE_W-1:0] hit_right_before;
    logic [SAMPLE_W-1:0] hit_left;
    logic [SAMPLE_W-1:0] hit_left_before;
    logic [LEVEL_W-1:0]  shake_amount;
    logic                rest_left;
    logic                rest_right;
  } out_t;

endpackage

// ----- rtl/core/abgt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module abgt_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/accel_beat_gesture_trigger.sv -----
// Accelerometer beat and gesture trigger, one axis: top level.
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  input   | in_valid / in_ready / in_data  | abgt_pkg::in_t  (sample, time)
//  result  | out_valid/ out_ready/ out_data | abgt_pkg::out_t (hits, shake, rest)
//  config  | cfg_valid/ cfg_ready/ cfg_*    | 3 b index, 16 b write data
//
// One sample per cycle sustained while the result is not stalled; an input
// transfer reaches out_valid via the input register, then the result register.
// The window is a RAM read one sample ahead: the pointer steps by one per
// sample, so the next tap is prefetched while the current one is written.
// Reset (synchronous, rst_n low) presets config and state, not data registers
// or RAM; window entries read as zero until written, tracked by one fill bit
// per tap. A stalled result holds the result register; the input register
// then holds one more sample before in_ready drops.
module accel_beat_gesture_trigger #(
  parameter int unsigned WINDOW_TAPS = 16   // power of two, 2..256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  abgt_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output abgt_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [abgt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [abgt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import abgt_pkg::*;

  localparam int unsigned POS_W = $clog2(WINDOW_TAPS);
  localparam int unsigned SUM_W = POS_W + SAMPLE_W;

  // ---------------------------------------------------------------- config
  logic [SAMPLE_W-1:0] trigger_diff_r;
  logic [DELAY_W-1:0]  retrigger_delay_r;
  logic [LEVEL_W-1:0]  shake_level_r;
  logic [HOLD_W-1:0]   gesture_hold_r;
  logic [LEVEL_W-1:0]  rest_level_r;
  logic [SAMPLE_W-1:0] rest_low_mean_r;
  logic [SAMPLE_W-1:0] rest_high_mean_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_diff_r    <= TRIGGER_DIFF_RST;
      retrigger_delay_r <= RETRIGGER_DELAY_RST;
      shake_level_r     <= SHAKE_LEVEL_RST;
      gesture_hold_r    <= GESTURE_HOLD_RST;
      rest_level_r      <= REST_LEVEL_RST;
      rest_low_mean_r   <= REST_LOW_MEAN_RST;
      rest_high_mean_r  <= REST_HIGH_MEAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TRIGGER_DIFF:    trigger_diff_r    <= cfg_data[SAMPLE_W-1:0];
        REG_RETRIGGER_DELAY: retrigger_delay_r <= cfg_data[DELAY_W-1:0];
        REG_SHAKE_LEVEL:     shake_level_r     <= cfg_data[LEVEL_W-1:0];
        REG_GESTURE_HOLD:    gesture_hold_r    <= cfg_data[HOLD_W-1:0];
        REG_REST_LEVEL:      rest_level_r      <= cfg_data[LEVEL_W-1:0];
        REG_REST_LOW_MEAN:   rest_low_mean_r   <= cfg_data[SAMPLE_W-1:0];
        REG_REST_HIGH_MEAN:  rest_high_mean_r  <= cfg_data[SAMPLE_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // -------------------------------------------------------------- pipeline
  logic  s1_vld_r;
  in_t   s1_data_r;
  logic  out_vld_r;
  out_t  out_data_r;
  logic  advance;

  assign advance   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------ state
  logic [POS_W-1:0]       pos_r;
  logic [WINDOW_TAPS-1:0] fill_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_W-1:0]    last_r;
  logic [LEVEL_W-1:0]     dsum_r;
  logic                   armed_r;
  logic [TIME_W-1:0]      deadline_r;
  logic [SAMPLE_W-1:0]    right_now_r;
  logic [SAMPLE_W-1:0]    left_now_r;
  logic [LEVEL_W-1:0]     shake_latched_r;
  logic [1:0]             rest_flags_r;   // bit0 left, bit1 right
  logic [HOLD_W-1:0]      shake_wait_r;
  logic [HOLD_W-1:0]      rest_wait_r;
  logic [HOLD_W-1:0]      idle_wait_r;

  // Window RAM, one tap prefetched
  logic [POS_W-1:0]    pos_nxt;
  logic [POS_W-1:0]    ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign pos_nxt   = (pos_r == POS_W'(WINDOW_TAPS - 1)) ? '0 : pos_r + 1'b1;
  assign ram_raddr = advance ? pos_nxt : pos_r;

  abgt_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_TAPS)
  ) u_window (
    .clk   (clk),
    .we    (advance),
    .waddr (pos_r),
    .wdata (s1_data_r.sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------ datapath
  logic [SAMPLE_W-1:0] s;
  logic [SAMPLE_W-1:0] old_tap;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0] dev;
  logic [11:0]         s12, last12, mean12, td12;
  logic                fall, rise;
  logic [TIME_W-1:0]   elapsed;
  logic                armed_eff;
  logic                hit_r, hit_l;
  logic [LEVEL_W-1:0]  dsum_nxt;
  logic                resting;
  logic [19:0]         delay_x10;
  logic [TIME_W-1:0]   now;

  logic                armed_nxt;
  logic [TIME_W-1:0]   deadline_nxt;
  logic [LEVEL_W-1:0]  shake_latched_nxt;
  logic [1:0]          rest_flags_nxt;
  logic [HOLD_W-1:0]   shake_wait_nxt, rest_wait_nxt, idle_wait_nxt;
  out_t                res;

  always_comb begin
    s       = s1_data_r.sample;
    now     = s1_data_r.time_ms;
    old_tap = fill_r[pos_r] ? ram_rdata : '0;
    sum_nxt = sum_r - {{POS_W{1'b0}}, old_tap} + {{POS_W{1'b0}}, s};
    mean    = sum_nxt[SUM_W-1:POS_W];
    dev     = (s >= mean) ? s - mean : mean - s;

    s12    = {2'b00, s};
    last12 = {2'b00, last_r};
    mean12 = {2'b00, mean};
    td12   = {2'b00, trigger_diff_r};
    fall   = (s12 + td12 < last12) && (s12 + (td12 << 1) < mean12);
    rise   = (s12 > last12 + td12) && (s12 > mean12 + (td12 << 1));

    // lockout ends once now is strictly past the deadline (wrap-aware)
    elapsed   = now - deadline_r;
    armed_eff = armed_r || ((elapsed != '0) && !elapsed[TIME_W-1]);
    hit_r     = fall && armed_eff;
    hit_l     = rise && armed_eff && !hit_r;

    armed_nxt    = armed_eff && !hit_r && !hit_l;
    deadline_nxt = (hit_r || hit_l) ? now + {16'd0, retrigger_delay_r} : deadline_r;

    dsum_nxt  = {1'b0, dsum_r[LEVEL_W-1:1]} + {1'b0, dev};
    resting   = dsum_nxt < rest_level_r;
    delay_x10 = ({4'd0, retrigger_delay_r} << 3) + ({4'd0, retrigger_delay_r} << 1);

    shake_latched_nxt = shake_latched_r;
    rest_flags_nxt    = rest_flags_r;
    shake_wait_nxt    = shake_wait_r;
    rest_wait_nxt     = rest_wait_r;
    idle_wait_nxt     = idle_wait_r;

    priority if (dsum_nxt > shake_level_r) begin
      if (shake_wait_r == '0) begin
        if (armed_nxt) begin
          shake_latched_nxt = dsum_nxt;
          armed_nxt         = 1'b0;
          deadline_nxt      = now + {12'd0, delay_x10};
          rest_flags_nxt    = 2'b00;
        end else begin
          shake_latched_nxt = '0;   // shake during lockout reports nothing
        end
      end else begin
        shake_wait_nxt = shake_wait_r - 1'b1;
      end
      rest_wait_nxt = gesture_hold_r;
      idle_wait_nxt = gesture_hold_r;
    end else if (resting && (mean < rest_low_mean_r)) begin
      if (rest_wait_r == '0) begin
        rest_flags_nxt    = 2'b01;
        shake_latched_nxt = '0;
      end else begin
        rest_wait_nxt = rest_wait_r - 1'b1;
      end
      shake_wait_nxt = gesture_hold_r;
      idle_wait_nxt  = gesture_hold_r;
    end else if (resting && (mean > rest_high_mean_r)) begin
      if (rest_wait_r == '0) begin
        rest_flags_nxt    = 2'b10;
        shake_latched_nxt = '0;
      end else begin
        rest_wait_nxt = rest_wait_r - 1'b1;
      end
      shake_wait_nxt = gesture_hold_r;
      idle_wait_nxt  = gesture_hold_r;
    end else begin
      rest_wait_nxt  = gesture_hold_r;
      shake_wait_nxt = gesture_hold_r;
      if (idle_wait_r == '0) begin
        rest_flags_nxt    = 2'b00;
        shake_latched_nxt = '0;
      end else begin
        idle_wait_nxt = idle_wait_r - 1'b1;
      end
    end

    res.hit_right        = hit_r ? dev : '0;
    res.hit_right_before = right_now_r;
    res.hit_left         = hit_l ? dev : '0;
    res.hit_left_before  = left_now_r;
    res.shake_amount     = shake_latched_nxt;
    res.rest_left        = rest_flags_nxt[0];
    res.rest_right       = rest_flags_nxt[1];
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      pos_r           <= '0;
      fill_r          <= '0;
      sum_r           <= '0;
      last_r          <= '0;
      dsum_r          <= '0;
      armed_r         <= 1'b1;
      deadline_r      <= '0;
      right_now_r     <= '0;
      left_now_r      <= '0;
      shake_latched_r <= '0;
      rest_flags_r    <= 2'b00;
      shake_wait_r    <= GESTURE_HOLD_RST;
      rest_wait_r     <= GESTURE_HOLD_RST;
      idle_wait_r     <= GESTURE_HOLD_RST;
    end else begin
      if (in_valid && in_ready) begin
        s1_vld_r  <= 1'b1;
        s1_data_r <= in_data;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end

      if (advance) begin
        out_vld_r  <= 1'b1;
        out_data_r <= res;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end

      if (advance) begin
        pos_r           <= pos_nxt;
        fill_r[pos_r]   <= 1'b1;
        sum_r           <= sum_nxt;
        last_r          <= s;
        dsum_r          <= dsum_nxt;
        armed_r         <= armed_nxt;
        deadline_r      <= deadline_nxt;
        right_now_r     <= res.hit_right;
        left_now_r      <= res.hit_left;
        shake_latched_r <= shake_latched_nxt;
        rest_flags_r    <= rest_flags_nxt;
        shake_wait_r    <= shake_wait_nxt;
        rest_wait_r     <= rest_wait_nxt;
        idle_wait_r     <= idle_wait_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // only one rest direction at a time
  a_rest_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(rest_flags_r))
    else $error("rest flags both set");

  // shake latch and rest flags clear each other
  a_shake_rest_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !((shake_latched_r != '0) && (rest_flags_r != 2'b00)))
    else $error("shake latched while resting");

  // a hit starts a lockout
  a_hit_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (hit_r || hit_l)) |=> !armed_r)
    else $error("armed after a hit");

  // a result never carries both hit directions
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !((out_data_r.hit_right != '0) && (out_data_r.hit_left != '0)))
    else $error("both hits reported");

  // an empty result register never throttles the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with free result register");
`endif

endmodule
